/* src/dsc_pkg.sv */
// shared types and constants for the divisible subarray counter
// no dependencies; imported by the front, queue, back and top level modules
`default_nettype none

package dsc_pkg;

   // field widths of the ports
   localparam int VALUE_W    = 31;
   localparam int MODULUS_W  = 11;
   localparam int TOTAL_W    = 63;
   localparam int RESIDUE_W  = 10;

   // remainder unit: dividend bits retired per cycle
   localparam int STEP_BITS  = 2;
   localparam int DIV_CYCLES = (VALUE_W + STEP_BITS - 1) / STEP_BITS;
   localparam int DIV_BITS   = DIV_CYCLES * STEP_BITS;
   localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

   // histogram entries carry an epoch tag so a new array needs no clear
   localparam int EPOCH_W    = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST = {EPOCH_W{1'b1}};

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_DIVIDE,
      FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_SWEEP,
      BK_IDLE,
      BK_LOOKUP,
      BK_UPDATE,
      BK_REDUCE
   } back_state_type;

endpackage

`default_nettype wire

/* src/dsc_front.sv */
// front end: modulus register, input acceptance and value-mod-modulus reduction
// depends on dsc_pkg; feeds dsc_queue with {first, modulus, reduced value}
`default_nettype none

module dsc_front #(
   parameter int MAX_MODULUS = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [dsc_pkg::MODULUS_W-1:0]        csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dsc_pkg::VALUE_W-1:0]          req_value,
   input  logic                                 req_first,
   input  logic                                 sweep_busy,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output logic [$clog2(MAX_MODULUS+1)+$clog2(MAX_MODULUS):0] push_data
);
   import dsc_pkg::*;

   localparam int EM_W  = $clog2(MAX_MODULUS + 1);
   localparam int RES_W = $clog2(MAX_MODULUS);
   localparam int CMP_W = (EM_W > MODULUS_W) ? EM_W : MODULUS_W;

   front_state_type       state_ff, state_in;
   logic [MODULUS_W-1:0]  modulus_ff;
   logic [DIV_BITS-1:0]   dividend_ff, dividend_in;
   logic [EM_W-1:0]       rem_ff, rem_in;
   logic [EM_W-1:0]       mod_ff, mod_in;
   logic                  first_ff, first_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CMP_W-1:0]      mod_ext;
   logic [EM_W-1:0]       mod_eff;
   logic [EM_W-1:0]       rem_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_W'(1);
      end else if (csr_we) begin
         modulus_ff <= csr_wdata;
      end
   end

   // zero acts as one, anything above the histogram size clamps to it
   always_comb begin
      mod_ext = CMP_W'(modulus_ff);
      if (mod_ext == '0) begin
         mod_eff = EM_W'(1);
      end else if (mod_ext > CMP_W'(MAX_MODULUS)) begin
         mod_eff = EM_W'(MAX_MODULUS);
      end else begin
         mod_eff = mod_ext[EM_W-1:0];
      end
   end

   // restoring remainder, STEP_BITS dividend bits per cycle
   always_comb begin
      logic [EM_W:0]   part;
      logic [EM_W-1:0] r;
      r = rem_ff;
      part = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         part = {r, dividend_ff[DIV_BITS-1-i]};
         if (part >= {1'b0, mod_ff}) begin
            part = part - {1'b0, mod_ff};
         end
         r = part[EM_W-1:0];
      end
      rem_step = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      mod_ff      <= mod_in;
      first_ff    <= first_in;
      cnt_ff      <= cnt_in;
   end

   always_comb begin
      state_in    = state_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      mod_in      = mod_ff;
      first_in    = first_ff;
      cnt_in      = cnt_ff;
      req_ready   = 1'b0;
      push_valid  = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            req_ready = !sweep_busy;
            if (req_valid && !sweep_busy) begin
               dividend_in = DIV_BITS'(req_value);
               rem_in      = '0;
               mod_in      = mod_eff;
               first_in    = req_first;
               cnt_in      = '0;
               state_in    = FR_DIVIDE;
            end
         end
         FR_DIVIDE: begin
            rem_in      = rem_step;
            dividend_in = dividend_ff << STEP_BITS;
            cnt_in      = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
               state_in = FR_PUSH;
            end
         end
         FR_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = FR_IDLE;
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   assign push_data = {first_ff, mod_ff, rem_ff[RES_W-1:0]};

   a_rem_below_mod: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FR_PUSH) |-> (rem_ff < mod_ff))
      else $error("reduced value not below modulus");

endmodule

`default_nettype wire

/* src/dsc_queue.sv */
// short fifo between the front end and the histogram back end
// depends on dsc_pkg for its depth
`default_nettype none

module dsc_queue #(
   parameter int DATA_W = 22
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);
   import dsc_pkg::*;

   logic [DATA_W-1:0]      entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   push_fire;
   logic                   pop_fire;

   assign push_ready = (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + (QUEUE_PTR_W+1)'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - (QUEUE_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push_fire && !pop_fire) |=> (count_ff == $past(count_ff) + (QUEUE_PTR_W+1)'(1)))
      else $error("queue count did not follow a push");

endmodule

`default_nettype wire

/* src/dsc_back.sv */
// back end: prefix residue, epoch-tagged residue histogram and running total
// depends on dsc_pkg; pops work from dsc_queue and drives the response channel
`default_nettype none

module dsc_back #(
   parameter int MAX_MODULUS = 1024,
   parameter int COUNT_BITS  = 21
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  logic [$clog2(MAX_MODULUS+1)+$clog2(MAX_MODULUS):0] pop_data,
   output logic                                 sweep_busy,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dsc_pkg::TOTAL_W-1:0]          rsp_total,
   output logic [dsc_pkg::RESIDUE_W-1:0]        rsp_residue
);
   import dsc_pkg::*;

   localparam int EM_W      = $clog2(MAX_MODULUS + 1);
   localparam int RES_W     = $clog2(MAX_MODULUS);
   localparam int DATA_W    = 1 + EM_W + RES_W;
   localparam int MEM_W     = EPOCH_W + COUNT_BITS;
   localparam int RED_CNT_W = (RES_W > 1) ? $clog2(RES_W) : 1;

   back_state_type         state_ff, state_in;
   logic [RES_W-1:0]       sweep_addr_ff, sweep_addr_in;
   logic [EPOCH_W-1:0]     epoch_ff, epoch_in;
   logic [RES_W-1:0]       prefix_ff, prefix_in;
   logic [TOTAL_W-1:0]     total_ff, total_in;
   logic [RES_W-1:0]       r_ff, r_in;
   logic [EM_W-1:0]        m_ff, m_in;
   logic [EM_W-1:0]        red_rem_ff, red_rem_in;
   logic [RED_CNT_W-1:0]   red_cnt_ff, red_cnt_in;
   logic [MEM_W-1:0]       rdata_ff;
   logic [MEM_W-1:0]       hist_ff [MAX_MODULUS];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0]     rsp_total_ff, rsp_total_in;
   logic [RES_W-1:0]       rsp_res_ff, rsp_res_in;

   logic                   mem_we;
   logic [RES_W-1:0]       mem_waddr;
   logic [MEM_W-1:0]       mem_wdata;

   logic [RES_W-1:0]       q_vmod;
   logic [EM_W-1:0]        q_mod;
   logic                   q_first;
   logic                   out_free;
   logic                   upd_go;
   logic                   sweep_last;
   logic [RES_W+RESIDUE_W-1:0] res_wide;

   assign q_vmod  = pop_data[RES_W-1:0];
   assign q_mod   = pop_data[RES_W +: EM_W];
   assign q_first = pop_data[DATA_W-1];

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign upd_go     = (state_ff == BK_UPDATE) && out_free;
   assign sweep_last = (sweep_addr_ff == RES_W'(MAX_MODULUS - 1));
   assign sweep_busy = (state_ff == BK_SWEEP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_SWEEP;
         sweep_addr_ff <= '0;
         epoch_ff      <= '0;
         prefix_ff     <= '0;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         epoch_ff      <= epoch_in;
         prefix_ff     <= prefix_in;
         total_ff      <= total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff         <= r_in;
      m_ff         <= m_in;
      red_rem_ff   <= red_rem_in;
      red_cnt_ff   <= red_cnt_in;
      rsp_total_ff <= rsp_total_in;
      rsp_res_ff   <= rsp_res_in;
   end

   // histogram memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_ff[mem_waddr] <= mem_wdata;
      end
      if (state_ff == BK_LOOKUP) begin
         rdata_ff <= hist_ff[r_ff];
      end
   end

   always_comb begin
      logic [RES_W-1:0]      base;
      logic [EM_W:0]         sum;
      logic [EM_W:0]         part;
      logic [COUNT_BITS-1:0] cnt;
      logic [COUNT_BITS:0]   add;
      logic [TOTAL_W:0]      grown;
      state_in      = state_ff;
      sweep_addr_in = sweep_addr_ff;
      epoch_in      = epoch_ff;
      prefix_in     = prefix_ff;
      total_in      = total_ff;
      r_in          = r_ff;
      m_in          = m_ff;
      red_rem_in    = red_rem_ff;
      red_cnt_in    = red_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_total_in  = rsp_total_ff;
      rsp_res_in    = rsp_res_ff;
      pop_ready     = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = r_ff;
      mem_wdata     = '0;
      base          = '0;
      sum           = '0;
      part          = '0;
      cnt           = '0;
      add           = '0;
      grown         = '0;
      case (state_ff)
         BK_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_ff;
            mem_wdata = '0;
            if (sweep_last) begin
               epoch_in      = '0;
               sweep_addr_in = '0;
               state_in      = BK_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + RES_W'(1);
            end
         end
         BK_IDLE: begin
            if (pop_valid) begin
               // out of epoch tags: wipe the histogram before the new array
               if (q_first && (epoch_ff == EPOCH_LAST)) begin
                  sweep_addr_in = '0;
                  state_in      = BK_SWEEP;
               end else if (!q_first && (EM_W'(prefix_ff) >= q_mod)) begin
                  // modulus lowered mid-array: carried residue needs a full reduction
                  red_rem_in = '0;
                  red_cnt_in = '0;
                  state_in   = BK_REDUCE;
               end else begin
                  pop_ready = 1'b1;
                  base = q_first ? '0 : prefix_ff;
                  sum  = (EM_W+1)'(base) + (EM_W+1)'(q_vmod);
                  if (sum >= (EM_W+1)'(q_mod)) begin
                     sum = sum - (EM_W+1)'(q_mod);
                  end
                  r_in      = sum[RES_W-1:0];
                  prefix_in = sum[RES_W-1:0];
                  m_in      = q_mod;
                  if (q_first) begin
                     epoch_in = epoch_ff + EPOCH_W'(1);
                     total_in = '0;
                  end
                  state_in = BK_LOOKUP;
               end
            end
         end
         BK_REDUCE: begin
            // restoring remainder of the prefix residue, one bit per cycle, msb first
            part = {red_rem_ff, prefix_ff[RES_W-1]};
            if (part >= {1'b0, q_mod}) begin
               part = part - {1'b0, q_mod};
            end
            red_rem_in = part[EM_W-1:0];
            prefix_in  = prefix_ff << 1;
            red_cnt_in = red_cnt_ff + RED_CNT_W'(1);
            if (red_cnt_ff == RED_CNT_W'(RES_W - 1)) begin
               prefix_in = part[RES_W-1:0];
               state_in  = BK_IDLE;
            end
         end
         BK_LOOKUP: begin
            state_in = BK_UPDATE;
         end
         BK_UPDATE: begin
            if (out_free) begin
               // an entry tagged with an older epoch counts as zero
               if (rdata_ff[MEM_W-1 -: EPOCH_W] == epoch_ff) begin
                  cnt = rdata_ff[COUNT_BITS-1:0];
               end
               add   = (COUNT_BITS+1)'(cnt) + (COUNT_BITS+1)'(r_ff == '0);
               grown = (TOTAL_W+1)'(total_ff) + (TOTAL_W+1)'(add);
               total_in = grown[TOTAL_W] ? TOTAL_MAX : grown[TOTAL_W-1:0];
               mem_we    = 1'b1;
               mem_waddr = r_ff;
               mem_wdata = {epoch_ff, (&cnt) ? cnt : cnt + COUNT_BITS'(1)};
               rsp_valid_in = 1'b1;
               rsp_total_in = grown[TOTAL_W] ? TOTAL_MAX : grown[TOTAL_W-1:0];
               rsp_res_in   = r_ff;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign res_wide    = (RES_W+RESIDUE_W)'(rsp_res_ff);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_total   = rsp_total_ff;
   assign rsp_residue = res_wide[RESIDUE_W-1:0];

   a_update_loads: assert property (@(posedge clock) disable iff (reset)
      upd_go |=> rsp_valid_ff)
      else $error("update did not load the response register");

   a_total_grows: assert property (@(posedge clock) disable iff (reset)
      upd_go |=> (total_ff >= $past(total_ff)))
      else $error("running total went down within an array");

   a_residue_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_LOOKUP) |-> ((EM_W+1)'(r_ff) < (EM_W+1)'(m_ff)))
      else $error("prefix residue not below modulus");

   a_sweep_epoch: assert property (@(posedge clock) disable iff (reset)
      (sweep_busy && sweep_last) |=> (epoch_ff == '0 && state_ff == BK_IDLE))
      else $error("sweep did not restart the epoch");

endmodule

`default_nettype wire

/* src/divisible_subarray_counter.sv */
// divisible_subarray_counter: counts contiguous subarrays whose sum is a
// multiple of the programmed modulus, one array element per request.
// Request channel (req_valid/req_ready): req_value is the next element,
// req_first starts a new array and clears the histogram and total.
// Response channel (rsp_valid/rsp_ready): one transaction per request, with
// rsp_total (saturating count so far) and rsp_residue (prefix sum mod modulus).
// csr_we/csr_wdata write the modulus (0 acts as 1, above MAX_MODULUS clamps);
// write it only while no request is in flight.
// The front end remainder unit retires 2 dividend bits per cycle and holds
// one request at a time. The response is registered after the front end
// reduction, the queue and the back end lookup and update states; a modulus
// lowered mid-array first sends the prefix residue through the reduce state.
// After reset the back end clears every histogram entry with req_ready low;
// the same pass runs after every 255 arrays, when its epoch tags run out.
// A stalled receiver holds the response register; the queue still takes up
// to two reduced requests before req_ready drops.
// depends on dsc_pkg, dsc_front, dsc_queue and dsc_back
`default_nettype none

module divisible_subarray_counter #(
   parameter int MAX_MODULUS = 1024,
   parameter int COUNT_BITS  = 21
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [dsc_pkg::MODULUS_W-1:0]  csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [dsc_pkg::VALUE_W-1:0]    req_value,
   input  logic                           req_first,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dsc_pkg::TOTAL_W-1:0]    rsp_total,
   output logic [dsc_pkg::RESIDUE_W-1:0]  rsp_residue
);
   import dsc_pkg::*;

   localparam int DATA_W = 1 + $clog2(MAX_MODULUS + 1) + $clog2(MAX_MODULUS);

   logic              push_valid;
   logic              push_ready;
   logic [DATA_W-1:0] push_data;
   logic              pop_valid;
   logic              pop_ready;
   logic [DATA_W-1:0] pop_data;
   logic              sweep_busy;

   dsc_front #(
      .MAX_MODULUS (MAX_MODULUS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .req_first  (req_first),
      .sweep_busy (sweep_busy),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   dsc_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   dsc_back #(
      .MAX_MODULUS (MAX_MODULUS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .sweep_busy  (sweep_busy),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_total   (rsp_total),
      .rsp_residue (rsp_residue)
   );

endmodule

`default_nettype wire

/* test/tb_divisible_subarray_counter.sv */
// testbench for divisible_subarray_counter: directed and random element streams
// checked against an in-bench model of the prefix residue histogram
// depends on dsc_pkg and the divisible_subarray_counter rtl
`timescale 1ns / 1ps

module tb_divisible_subarray_counter;

   import dsc_pkg::*;

   localparam int MAX_MODULUS  = 1024;
   localparam int COUNT_BITS   = 21;
   localparam int ITEM_TARGET  = 1500;
   localparam int DRAIN_CYCLES = 24;
   localparam int STALL_LIMIT  = 5000;
   localparam int REPORT_LIMIT = 10;

   localparam logic [VALUE_W-1:0]    VALUE_MAX   = {VALUE_W{1'b1}};
   localparam logic [63:0]           TOTAL_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};

   typedef struct packed {
      logic [TOTAL_W-1:0]   total;
      logic [RESIDUE_W-1:0] residue;
   } subarray_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [MODULUS_W-1:0] csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [VALUE_W-1:0]   req_value = '0;
   logic                 req_first = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [TOTAL_W-1:0]   rsp_total;
   logic [RESIDUE_W-1:0] rsp_residue;

   // model state
   logic [MODULUS_W-1:0]  model_modulus;
   int unsigned           prefix_residue;
   logic [COUNT_BITS-1:0] residue_hist [MAX_MODULUS];
   logic [TOTAL_W-1:0]    running_total;
   subarray_result_type   expected_results [$];
   subarray_result_type   oldest_expected;

   int  req_accepts = 0;
   int  responses_checked = 0;
   int  arrays_started = 0;
   int  csr_writes = 0;
   int  items_sent = 0;
   int  mismatches = 0;
   int  stall_cycles = 0;
   int  stall_left = 0;
   int  hold_request = 0;
   bit  steady_flow = 1'b0;

   divisible_subarray_counter #(
      .MAX_MODULUS(MAX_MODULUS),
      .COUNT_BITS (COUNT_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .req_first  (req_first),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_total  (rsp_total),
      .rsp_residue(rsp_residue)
   );

   always #5 clock = ~clock;

   // zero acts as one, anything above the histogram size clamps to it
   function automatic int unsigned active_modulus(logic [MODULUS_W-1:0] m);
      if (m == 0)
         return 1;
      if (m > MAX_MODULUS)
         return MAX_MODULUS;
      return m;
   endfunction

   function automatic subarray_result_type tally_element(logic [VALUE_W-1:0] elem,
                                                         logic is_first);
      int unsigned         m;
      int unsigned         r;
      logic [63:0]         sum;
      subarray_result_type res;
      m = active_modulus(model_modulus);
      if (is_first) begin
         foreach (residue_hist[i])
            residue_hist[i] = '0;
         prefix_residue = 0;
         running_total = '0;
      end
      r = (prefix_residue + elem % m) % m;
      prefix_residue = r;
      sum = {1'b0, running_total} + 64'(residue_hist[r]) + 64'(r == 0);
      if (sum > TOTAL_LIMIT)
         sum = TOTAL_LIMIT;
      running_total = sum[TOTAL_W-1:0];
      if (residue_hist[r] != COUNT_LIMIT)
         residue_hist[r] = residue_hist[r] + 1'b1;
      res.total = running_total;
      res.residue = r[RESIDUE_W-1:0];
      return res;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [MODULUS_W-1:0] pick_modulus();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return MODULUS_W'($urandom_range(1, 16));
         6: return MODULUS_W'($urandom_range(17, 1024));
         7: return ($urandom_range(0, 1) == 0) ? MODULUS_W'(0) : {MODULUS_W{1'b1}};
         8: return MODULUS_W'($urandom_range(1025, 2047));
         default: return MODULUS_W'($urandom_range(2, 64));
      endcase
   endfunction

   // small values and multiples keep residues colliding
   function automatic logic [VALUE_W-1:0] pick_value(int unsigned m);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return VALUE_W'($urandom_range(0, 3 * m));
         4, 5: return VALUE_W'(m * $urandom_range(0, 1000));
         6: return '0;
         7: return VALUE_MAX - VALUE_W'($urandom_range(0, m));
         default: return VALUE_W'($urandom());
      endcase
   endfunction

   // receiver: random stalls, or a long hold when a test asks for one
   always @(negedge clock) begin
      if (hold_request > 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end else if (stall_left == 0 && !steady_flow && $urandom_range(0, 3) == 0)
         stall_left = pick_gap();
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else
         rsp_ready <= 1'b1;
   end

   // sample every transaction, predict on requests, check responses, watchdog
   always @(posedge clock) begin
      if (reset) begin
         model_modulus = MODULUS_W'(1);
         prefix_residue = 0;
         running_total = '0;
         foreach (residue_hist[i])
            residue_hist[i] = '0;
         stall_cycles = 0;
      end else begin
         if (csr_we) begin
            model_modulus = csr_wdata;
            csr_writes++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected response: total=%0d residue=%0d",
                           rsp_total, rsp_residue);
            end else begin
               oldest_expected = expected_results.pop_front();
               responses_checked++;
               if (rsp_total !== oldest_expected.total ||
                   rsp_residue !== oldest_expected.residue) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"response %0d: expected total=%0d residue=%0d,",
                               " got total=%0d residue=%0d"},
                              responses_checked, oldest_expected.total,
                              oldest_expected.residue, rsp_total, rsp_residue);
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_results.push_back(tally_element(req_value, req_first));
            req_accepts++;
            if (req_first)
               arrays_started++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
                     STALL_LIMIT, expected_results.size());
            $display("divisible_subarray_counter: mismatch");
            $finish;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_element(input logic [VALUE_W-1:0] elem, input logic is_first);
      int gap;
      int seen;
      gap = steady_flow ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= elem;
      req_first <= is_first;
      seen = req_accepts;
      do begin
         @(negedge clock);
      end while (req_accepts == seen);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic reprogram_modulus(input logic [MODULUS_W-1:0] m);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // no first flag: histogram must already be clear, modulus still at reset value
   task automatic test_after_reset();
      send_element('0, 1'b0);
      send_element(VALUE_MAX, 1'b0);
      send_element(VALUE_W'(5), 1'b0);
   endtask

   task automatic test_modulus_extremes();
      reprogram_modulus('0);
      send_element(VALUE_MAX, 1'b1);
      send_element(VALUE_W'(3), 1'b0);
      reprogram_modulus({MODULUS_W{1'b1}});
      send_element(VALUE_MAX, 1'b1);
      send_element(VALUE_W'(1023), 1'b0);
      send_element(VALUE_W'(1), 1'b0);
      reprogram_modulus(MODULUS_W'(1024));
      send_element(VALUE_W'(1024), 1'b1);
      send_element('0, 1'b0);
      send_element(VALUE_MAX, 1'b0);
      reprogram_modulus(MODULUS_W'(2));
      send_element(VALUE_W'(1), 1'b1);
      send_element(VALUE_W'(1), 1'b0);
      send_element(VALUE_W'(2), 1'b0);
      reprogram_modulus(MODULUS_W'(7));
      send_element(VALUE_W'(6), 1'b1);
      send_element(VALUE_W'(8), 1'b0);
      send_element(VALUE_MAX, 1'b0);
   endtask

   // old histogram entries survive a modulus change within an array
   task automatic test_modulus_change();
      reprogram_modulus(MODULUS_W'(5));
      send_element(VALUE_W'(3), 1'b1);
      send_element(VALUE_W'(4), 1'b0);
      send_element(VALUE_W'(3), 1'b0);
      reprogram_modulus(MODULUS_W'(3));
      send_element(VALUE_W'(2), 1'b0);
      send_element(VALUE_W'(1), 1'b0);
      send_element(VALUE_W'(3), 1'b0);
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_backpressure();
      int unsigned m;
      m = $urandom_range(2, 8);
      reprogram_modulus(MODULUS_W'(m));
      steady_flow = 1'b1;
      hold_request = 300;
      for (int i = 0; i < 24; i++)
         send_element(pick_value(m), i == 0);
      steady_flow = 1'b0;
   endtask

   // sender stops until every response is back, then resumes the same array
   task automatic test_sender_pause();
      reprogram_modulus(MODULUS_W'(4));
      for (int i = 0; i < 10; i++)
         send_element(pick_value(4), i == 0);
      wait_drained();
      repeat ($urandom_range(1, 50)) @(negedge clock);
      for (int i = 0; i < 10; i++)
         send_element(pick_value(4), 1'b0);
   endtask

   task automatic test_random_arrays();
      logic [MODULUS_W-1:0] m;
      int unsigned          eff;
      int                   arrays;
      int                   len;
      bit                   carry_on;
      logic                 is_first;
      while (items_sent < ITEM_TARGET) begin
         steady_flow = ($urandom_range(0, 5) == 0);
         m = pick_modulus();
         eff = active_modulus(m);
         carry_on = ($urandom_range(0, 3) == 0);
         reprogram_modulus(m);
         arrays = $urandom_range(1, 12);
         for (int a = 0; a < arrays; a++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               // occasionally restart an array in the middle
               is_first = (i == 0 && !(a == 0 && carry_on)) || ($urandom_range(0, 39) == 0);
               send_element(pick_value(eff), is_first);
            end
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_after_reset();
      test_modulus_extremes();
      test_modulus_change();
      test_backpressure();
      test_sender_pause();
      test_random_arrays();
      wait_drained();
      $display("covered %0d elements over %0d arrays with %0d modulus writes",
               items_sent, arrays_started, csr_writes);
      $display("checked %0d responses, %0d mismatches", responses_checked, mismatches);
      if (mismatches == 0)
         $display("divisible_subarray_counter: match");
      else
         $display("divisible_subarray_counter: mismatch");
      $finish;
   end

endmodule
